### src/tmcg_pkg.sv
`default_nettype none
package tmcg_pkg;

  localparam int Samples = 50;
  localparam int CntW = (Samples > 1) ? $clog2(Samples) : 1;
  localparam int RemW = $clog2(Samples) + 1;
  localparam int One = 65536;
  localparam int OneThird = 21845;
  localparam int OvStep = One / Samples;
  localparam int OvRem = One % Samples;
  localparam int OvNW = $clog2(Samples * One + 1);
  localparam int OvShift = OvNW + $clog2(Samples);
  localparam int OvRecip = int'(((longint'(1) << OvShift) + Samples - 1) / Samples);
  localparam int LenShift = $clog2(One + 1) + $clog2(Samples);
  localparam int LenRecip = int'(((longint'(1) << LenShift) + Samples - 1) / Samples);
  localparam int PosW = 26;
  localparam int MuW = 17;
  localparam int AccW = 48;
  localparam int MulW = 36;
  localparam int DivNW = 64;
  localparam int DivDW = 56;

  typedef struct packed {
    logic signed [23:0] center;
    logic signed [23:0] width;
    logic signed [23:0] target_center;
    logic signed [23:0] target_width;
  } operands_t;

  typedef struct packed {
    logic signed [31:0] grad_center;
    logic signed [31:0] grad_width;
    logic signed [31:0] cost_total;
    logic signed [31:0] cost_overlap;
    logic signed [31:0] cost_center_sq;
    logic               zero_width;
  } result_t;

  typedef enum logic [0:0] {
    REG_OVERLAP_WEIGHT = 1'b0,
    REG_CENTER_WEIGHT  = 1'b1
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE, ST_OV_A, ST_OV_B, ST_OV_C, ST_OV_D, ST_OV_E, ST_OV_F,
    ST_CS_A, ST_CS_B, ST_CS_C,
    ST_AR_S, ST_AR_V, ST_AR_U, ST_AR_END,
    ST_PR_A, ST_PR_B, ST_PR_C,
    ST_GC_N, ST_GC_Q,
    ST_GW_L, ST_GW_A, ST_GW_B, ST_GW_C, ST_GW_D, ST_GW_E, ST_GW_F, ST_GW_G,
    ST_GW_H, ST_GW_Q,
    ST_MEM, ST_MEMW, ST_DIVW, ST_FIN
  } state_e;

  typedef struct packed {
    logic             start;
    logic [DivNW-1:0] dividend;
    logic [DivDW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DivNW-1:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi_lim;
    logic signed [63:0] lo_lim;
    hi_lim = 64'sd2147483647;
    lo_lim = -64'sd2147483648;
    if (v > hi_lim) return 32'sh7fffffff;
    else if (v < lo_lim) return 32'sh80000000;
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

### src/tmcg_div.sv
`default_nettype none
module tmcg_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tmcg_pkg::div_req_t req,
  output tmcg_pkg::div_rsp_t      rsp
);

  localparam int CntW = $clog2(tmcg_pkg::DivNW);

  logic                         running;
  logic                         done;
  logic [CntW-1:0]              cnt;
  logic [tmcg_pkg::DivDW-1:0]   rem;
  logic [tmcg_pkg::DivDW-1:0]   divisor;
  logic [tmcg_pkg::DivNW-1:0]   quo;
  logic [tmcg_pkg::DivDW:0]     rem_sh;
  logic [tmcg_pkg::DivDW:0]     diff;

  assign rem_sh = {rem, quo[tmcg_pkg::DivNW-1]};
  assign diff   = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !running) begin
        running <= 1'b1;
        cnt     <= '0;
        rem     <= '0;
        quo     <= req.dividend;
        divisor <= req.divisor;
      end else if (running) begin
        if (!diff[tmcg_pkg::DivDW]) begin
          rem <= diff[tmcg_pkg::DivDW-1:0];
          quo <= {quo[tmcg_pkg::DivNW-2:0], 1'b1};
        end else begin
          rem <= rem_sh[tmcg_pkg::DivDW-1:0];
          quo <= {quo[tmcg_pkg::DivNW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(tmcg_pkg::DivNW - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;

endmodule
`default_nettype wire

### src/triangular_membership_cost_gradient_core.sv
// Every division by a width runs on the 64-step restoring divider.
// Throughput: one item at a time; busy stays high until the result strobe.
// The result shows on result for the one cycle that done is high; the receiver cannot stall.
// Reset (rst, synchronous, active high) returns to idle and sets both weights to 1.0.
`default_nettype none
module triangular_membership_cost_gradient_core (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire tmcg_pkg::operands_t operands,
  output logic                     done,
  output tmcg_pkg::result_t        result,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [0:0]          cfg_index,
  input  wire logic [23:0]         cfg_data
);

  localparam int PosW = tmcg_pkg::PosW;
  localparam int MuW  = tmcg_pkg::MuW;
  localparam int MulW = tmcg_pkg::MulW;

  tmcg_pkg::state_e state, state_next, ret, pret;
  tmcg_pkg::div_req_t div_req;
  tmcg_pkg::div_rsp_t div_rsp;

  logic signed [23:0] ow, cw;
  logic signed [PosW-1:0] m, md, mx, mc, xq, xg, px, au_r, hold, pr, ares, a1, gnum;
  logic [23:0] b, bd, mh;
  logic [tmcg_pkg::CntW-1:0] idx;
  logic [tmcg_pkg::RemW-1:0] xr, lr;
  logic [MuW-1:0] mu, mu1, lq, overlap, len, lq_c;
  logic [tmcg_pkg::AccW-1:0] acc, s;
  logic [32:0] csq;
  logic signed [63:0] tot;
  logic [tmcg_pkg::DivDW-1:0] den;
  logic [63:0] slow;
  logic signed [31:0] gc, gw;
  logic aidx, plow;
  logic signed [MulW-1:0] mul_a, mul_b;
  logic signed [2*MulW-1:0] prod;

  logic signed [PosW-1:0] b_s, bd_s, mh_s, diff_m, dabs, xdiff, xabs;
  logic signed [PosW-1:0] u_raw, v_raw, au, av, lo, hi, pd, f, t, gmag;
  logic signed [PosW-1:0] mb_lo, mb_hi;
  logic mem_trivial, a_empty, p_zero, p_full, p_low, t_gt_f, zw, last;
  logic [tmcg_pkg::RemW-1:0] ov_sum, gw_sum;
  logic ov_wrap, gw_wrap;
  logic signed [63:0] qv;

  tmcg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign busy      = (state != tmcg_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  assign b_s    = PosW'(b);
  assign bd_s   = PosW'(bd);
  assign mh_s   = PosW'(mh);
  assign zw     = (b == '0);
  assign last   = (idx == tmcg_pkg::CntW'(tmcg_pkg::Samples - 1));
  assign diff_m = mx - mc;
  assign dabs   = (diff_m < 0) ? -diff_m : diff_m;
  assign mem_trivial = (mh == '0) || (dabs >= mh_s);
  assign xdiff  = xg - m;
  assign xabs   = (xdiff < 0) ? -xdiff : xdiff;

  assign u_raw   = aidx ? m : m - b_s;
  assign v_raw   = aidx ? m + b_s : m;
  assign au      = (u_raw < 0) ? '0 : u_raw;
  assign av      = (v_raw > tmcg_pkg::One) ? PosW'(tmcg_pkg::One) : v_raw;
  assign a_empty = (av <= au);

  assign lo     = md - bd_s;
  assign hi     = md + bd_s;
  assign p_zero = (px <= lo);
  assign p_full = (px >= hi);
  assign p_low  = (px <= md);
  assign pd     = p_low ? px - lo : hi - px;

  assign mb_lo  = m - b_s;
  assign mb_hi  = m + b_s;
  assign f      = (mb_lo < 0) ? '0 : mb_lo;
  assign t      = (mb_hi > tmcg_pkg::One) ? PosW'(tmcg_pkg::One) : mb_hi;
  assign t_gt_f = (t > f);
  assign gmag   = (gnum < 0) ? -gnum : gnum;

  assign ov_sum  = xr + tmcg_pkg::RemW'(tmcg_pkg::OvRem);
  assign ov_wrap = (ov_sum >= tmcg_pkg::RemW'(tmcg_pkg::Samples));
  assign gw_sum  = xr + lr;
  assign gw_wrap = (gw_sum >= tmcg_pkg::RemW'(tmcg_pkg::Samples));
  assign qv      = $signed(div_rsp.quotient);
  assign lq_c    = prod[tmcg_pkg::LenShift +: MuW];

  always_comb begin
    state_next = state;
    unique case (state)
      tmcg_pkg::ST_IDLE:   if (start) state_next = tmcg_pkg::ST_OV_A;
      tmcg_pkg::ST_OV_A:   state_next = tmcg_pkg::ST_MEM;
      tmcg_pkg::ST_OV_B:   state_next = tmcg_pkg::ST_MEM;
      tmcg_pkg::ST_OV_C:   state_next = tmcg_pkg::ST_OV_D;
      tmcg_pkg::ST_OV_D:   state_next = last ? tmcg_pkg::ST_OV_E : tmcg_pkg::ST_OV_A;
      tmcg_pkg::ST_OV_E:   state_next = tmcg_pkg::ST_OV_F;
      tmcg_pkg::ST_OV_F:   state_next = tmcg_pkg::ST_CS_A;
      tmcg_pkg::ST_CS_A:   state_next = tmcg_pkg::ST_CS_B;
      tmcg_pkg::ST_CS_B:   state_next = tmcg_pkg::ST_CS_C;
      tmcg_pkg::ST_CS_C:   state_next = zw ? tmcg_pkg::ST_FIN : tmcg_pkg::ST_AR_S;
      tmcg_pkg::ST_AR_S:
        state_next = (a_empty || bd == '0) ? tmcg_pkg::ST_AR_END : tmcg_pkg::ST_PR_A;
      tmcg_pkg::ST_AR_V:   state_next = tmcg_pkg::ST_PR_A;
      tmcg_pkg::ST_AR_U:   state_next = tmcg_pkg::ST_AR_END;
      tmcg_pkg::ST_AR_END: state_next = aidx ? tmcg_pkg::ST_GC_N : tmcg_pkg::ST_AR_S;
      tmcg_pkg::ST_PR_A:   state_next = (p_zero || p_full) ? pret : tmcg_pkg::ST_PR_B;
      tmcg_pkg::ST_PR_B:   state_next = tmcg_pkg::ST_DIVW;
      tmcg_pkg::ST_PR_C:   state_next = pret;
      tmcg_pkg::ST_GC_N:   state_next = tmcg_pkg::ST_DIVW;
      tmcg_pkg::ST_GC_Q:   state_next = t_gt_f ? tmcg_pkg::ST_GW_L : tmcg_pkg::ST_FIN;
      tmcg_pkg::ST_GW_L:   state_next = tmcg_pkg::ST_GW_A;
      tmcg_pkg::ST_GW_A:   state_next = tmcg_pkg::ST_MEM;
      tmcg_pkg::ST_GW_B:   state_next = tmcg_pkg::ST_GW_C;
      tmcg_pkg::ST_GW_C:   state_next = last ? tmcg_pkg::ST_GW_D : tmcg_pkg::ST_GW_A;
      tmcg_pkg::ST_GW_D:   state_next = tmcg_pkg::ST_GW_E;
      tmcg_pkg::ST_GW_E:   state_next = tmcg_pkg::ST_GW_F;
      tmcg_pkg::ST_GW_F:   state_next = tmcg_pkg::ST_GW_G;
      tmcg_pkg::ST_GW_G:   state_next = tmcg_pkg::ST_GW_H;
      tmcg_pkg::ST_GW_H:   state_next = tmcg_pkg::ST_DIVW;
      tmcg_pkg::ST_GW_Q:   state_next = tmcg_pkg::ST_FIN;
      tmcg_pkg::ST_MEM:    state_next = mem_trivial ? ret : tmcg_pkg::ST_MEMW;
      tmcg_pkg::ST_MEMW:   if (div_rsp.done) state_next = ret;
      tmcg_pkg::ST_DIVW:   if (div_rsp.done) state_next = ret;
      tmcg_pkg::ST_FIN:    state_next = tmcg_pkg::ST_IDLE;
      default:             state_next = tmcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    unique case (state)
      tmcg_pkg::ST_OV_C: begin
        mul_a = MulW'(mu1) - MulW'(mu);
        mul_b = MulW'(mu1) - MulW'(mu);
      end
      tmcg_pkg::ST_OV_E: begin
        mul_a = MulW'(acc[tmcg_pkg::AccW-1:16]);
        mul_b = MulW'(tmcg_pkg::OvRecip);
      end
      tmcg_pkg::ST_OV_F: begin
        mul_a = MulW'(m - md);
        mul_b = MulW'(m - md);
      end
      tmcg_pkg::ST_CS_A: begin
        mul_a = MulW'(ow);
        mul_b = MulW'(overlap);
      end
      tmcg_pkg::ST_CS_B: begin
        mul_a = MulW'(cw);
        mul_b = MulW'(csq);
      end
      tmcg_pkg::ST_PR_A: begin
        mul_a = MulW'(pd);
        mul_b = MulW'(pd);
      end
      tmcg_pkg::ST_PR_B: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod[63:0];
        div_req.divisor  = tmcg_pkg::DivDW'({bd, 1'b0});
      end
      tmcg_pkg::ST_GC_N: begin
        div_req.start    = 1'b1;
        div_req.dividend = tmcg_pkg::DivNW'(gmag) << 16;
        div_req.divisor  = tmcg_pkg::DivDW'(b);
      end
      tmcg_pkg::ST_GC_Q: begin
        mul_a = MulW'(t - f);
        mul_b = MulW'(tmcg_pkg::LenRecip);
      end
      tmcg_pkg::ST_GW_B: begin
        mul_a = MulW'(xabs);
        mul_b = MulW'(mu);
      end
      tmcg_pkg::ST_GW_D: begin
        mul_a = MulW'(tmcg_pkg::Samples);
        mul_b = MulW'(b);
      end
      tmcg_pkg::ST_GW_E: begin
        mul_a = prod[MulW-1:0];
        mul_b = MulW'(b);
      end
      tmcg_pkg::ST_GW_F: begin
        mul_a = MulW'(s[23:0]);
        mul_b = MulW'(len);
      end
      tmcg_pkg::ST_GW_G: begin
        mul_a = MulW'(s[tmcg_pkg::AccW-1:24]);
        mul_b = MulW'(len);
      end
      tmcg_pkg::ST_GW_H: begin
        div_req.start    = 1'b1;
        div_req.dividend = slow + (prod[63:0] << 24);
        div_req.divisor  = den;
      end
      tmcg_pkg::ST_MEM: begin
        div_req.start    = !mem_trivial;
        div_req.dividend = tmcg_pkg::DivNW'(dabs) << 16;
        div_req.divisor  = tmcg_pkg::DivDW'(mh);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmcg_pkg::ST_IDLE;
      done  <= 1'b0;
      ow    <= 24'sd65536;
      cw    <= 24'sd65536;
    end else begin
      state <= state_next;
      done  <= (state == tmcg_pkg::ST_FIN);
      if (cfg_valid && cfg_ready) begin
        unique case (tmcg_pkg::cfg_reg_e'(cfg_index))
          tmcg_pkg::REG_OVERLAP_WEIGHT: ow <= cfg_data;
          tmcg_pkg::REG_CENTER_WEIGHT:  cw <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      tmcg_pkg::ST_IDLE: begin
        m   <= PosW'(operands.center);
        md  <= PosW'(operands.target_center);
        b   <= operands.width[23] ? 24'(-operands.width) : 24'(operands.width);
        bd  <= operands.target_width[23] ? 24'(-operands.target_width)
                                         : 24'(operands.target_width);
        xq  <= '0;
        xr  <= '0;
        idx <= '0;
        acc <= '0;
        gc  <= '0;
        gw  <= '0;
      end
      tmcg_pkg::ST_OV_A: begin
        mx  <= xq;
        mc  <= m;
        mh  <= b;
        ret <= tmcg_pkg::ST_OV_B;
      end
      tmcg_pkg::ST_OV_B: begin
        mu1 <= mu;
        mc  <= md;
        mh  <= bd;
        ret <= tmcg_pkg::ST_OV_C;
      end
      tmcg_pkg::ST_OV_D: begin
        acc <= acc + prod[tmcg_pkg::AccW-1:0];
        idx <= idx + 1'b1;
        xq  <= xq + PosW'(tmcg_pkg::OvStep) + PosW'(ov_wrap);
        xr  <= ov_wrap ? ov_sum - tmcg_pkg::RemW'(tmcg_pkg::Samples) : ov_sum;
      end
      tmcg_pkg::ST_OV_F: overlap <= prod[tmcg_pkg::OvShift +: MuW];
      tmcg_pkg::ST_CS_A: csq <= prod[48:16];
      tmcg_pkg::ST_CS_B: tot <= prod[63:0];
      tmcg_pkg::ST_CS_C: begin
        tot  <= tot + prod[63:0];
        aidx <= 1'b0;
      end
      tmcg_pkg::ST_AR_S: begin
        au_r <= au;
        if (a_empty) begin
          ares <= '0;
        end else if (bd == '0) begin
          ares <= av - au;
        end else begin
          px   <= av;
          pret <= tmcg_pkg::ST_AR_V;
        end
      end
      tmcg_pkg::ST_AR_V: begin
        hold <= pr;
        px   <= au_r;
        pret <= tmcg_pkg::ST_AR_U;
      end
      tmcg_pkg::ST_AR_U: ares <= hold - pr;
      tmcg_pkg::ST_AR_END: begin
        if (!aidx) begin
          a1   <= ares;
          aidx <= 1'b1;
        end else begin
          gnum <= a1 - ares;
        end
      end
      tmcg_pkg::ST_PR_A: begin
        plow <= p_low;
        if (p_zero) pr <= '0;
        else if (p_full) pr <= bd_s;
      end
      tmcg_pkg::ST_PR_B: ret <= tmcg_pkg::ST_PR_C;
      tmcg_pkg::ST_PR_C: begin
        pr <= plow ? PosW'(div_rsp.quotient) : bd_s - PosW'(div_rsp.quotient);
      end
      tmcg_pkg::ST_GC_N: ret <= tmcg_pkg::ST_GC_Q;
      tmcg_pkg::ST_GC_Q: begin
        gc  <= tmcg_pkg::sat32((gnum < 0) ? -qv : qv);
        if (t_gt_f) len <= MuW'(t - f);
        else gw <= 32'(tmcg_pkg::OneThird);
      end
      tmcg_pkg::ST_GW_L: begin
        lq  <= lq_c;
        lr  <= tmcg_pkg::RemW'(len - MuW'(lq_c * MuW'(tmcg_pkg::Samples)));
        xg  <= f;
        xr  <= '0;
        idx <= '0;
        s   <= '0;
      end
      tmcg_pkg::ST_GW_A: begin
        mx  <= xg;
        mc  <= md;
        mh  <= bd;
        ret <= tmcg_pkg::ST_GW_B;
      end
      tmcg_pkg::ST_GW_C: begin
        s   <= s + prod[tmcg_pkg::AccW-1:0];
        idx <= idx + 1'b1;
        xg  <= xg + PosW'(lq) + PosW'(gw_wrap);
        xr  <= gw_wrap ? gw_sum - tmcg_pkg::RemW'(tmcg_pkg::Samples) : gw_sum;
      end
      tmcg_pkg::ST_GW_F: den <= prod[tmcg_pkg::DivDW-1:0];
      tmcg_pkg::ST_GW_G: slow <= prod[63:0];
      tmcg_pkg::ST_GW_H: ret <= tmcg_pkg::ST_GW_Q;
      tmcg_pkg::ST_GW_Q: gw <= tmcg_pkg::sat32(64'(tmcg_pkg::OneThird) - qv);
      tmcg_pkg::ST_MEM: begin
        if (mem_trivial) mu <= (mh == '0) ? MuW'(tmcg_pkg::One) : '0;
      end
      tmcg_pkg::ST_MEMW: begin
        if (div_rsp.done) mu <= MuW'(tmcg_pkg::One) - div_rsp.quotient[MuW-1:0];
      end
      tmcg_pkg::ST_FIN: begin
        result.grad_center    <= gc;
        result.grad_width     <= gw;
        result.cost_total     <= tmcg_pkg::sat32(tot >>> 16);
        result.cost_overlap   <= 32'(overlap);
        result.cost_center_sq <= tmcg_pkg::sat32(64'(csq));
        result.zero_width     <= zw;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

### src/tmcg_checker.sv
`default_nettype none
module tmcg_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              done,
  input wire tmcg_pkg::result_t result
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transfer did not raise busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  a_zero_grad: assert property (@(posedge clk) disable iff (rst)
    (done && result.zero_width) |->
      (result.grad_center == 32'sd0 && result.grad_width == 32'sd0))
    else $error("gradients nonzero at zero width");

  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

bind triangular_membership_cost_gradient_core tmcg_checker u_tmcg_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);
`default_nettype wire
